// ===== hdl/cnmd_pkg.sv =====
// Shared types, constants and the ring classifier for the crossing-number
// minutiae detector. No dependencies.
`default_nettype none
package cnmd_pkg;

  localparam int ORIENT_W   = 8;
  localparam int CFG_W      = 10;
  localparam int POS_OUT_W  = 9;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_ROWS = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_COLS = 3'd4;

  localparam logic MINUTIA_ENDING      = 1'b0;
  localparam logic MINUTIA_BIFURCATION = 1'b1;

  // Window bit positions of the clockwise ring N, NE, E, SE, S, SW, W, NW, N.
  localparam int RING_POS [9] = '{3, 0, 1, 2, 5, 8, 7, 6, 3};

  typedef struct packed {
    logic [ORIENT_W-1:0] orient;
    logic                ridge;
  } line_entry_t;

  typedef struct packed {
    line_entry_t middle;
    line_entry_t upper;
  } line_word_t;

  localparam int LINE_WORD_W = $bits(line_word_t);

  typedef struct packed {
    logic advance;
    logic item_valid;
    logic interior;
    logic restart;
  } stage_ctrl_t;

  typedef struct packed {
    logic hit;
    logic kind;
  } ring_class_t;

  function automatic ring_class_t classify_ring(logic [8:0] w);
    logic [3:0]  neigh;
    logic [3:0]  trans;
    logic [2:0]  cn;
    ring_class_t res;
    neigh = '0;
    trans = '0;
    for (int d = 0; d < 8; d++) begin
      neigh = neigh + 4'(w[RING_POS[d]]);
      trans = trans + 4'(w[RING_POS[d]] ^ w[RING_POS[d+1]]);
    end
    cn       = trans[3:1];
    res.hit  = ((neigh == 4'd1) && (cn == 3'd1)) || ((neigh == 4'd3) && (cn == 3'd3));
    res.kind = (neigh == 4'd3) ? MINUTIA_BIFURCATION : MINUTIA_ENDING;
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int hi);
    if (v < CFG_W'(3)) begin
      return CFG_W'(3);
    end
    if (32'(v) > hi) begin
      return CFG_W'(hi);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cnmd_cfg.sv =====
// APB register block holding the image size registers of the minutiae detector.
// Depends on cnmd_pkg.
`default_nettype none
module cnmd_cfg #(
  parameter int MAX_ROWS = 512,
  parameter int MAX_COLS = 512
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [cnmd_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [cnmd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [cnmd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output logic      [cnmd_pkg::CFG_W-1:0]         image_rows,
  output logic      [cnmd_pkg::CFG_W-1:0]         image_cols,
  output logic                                    restart
);
  import cnmd_pkg::*;

  localparam logic [CFG_W-1:0] ROWS_RESET = clamp_size(CFG_W'(512), MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_RESET = clamp_size(CFG_W'(512), MAX_COLS);

  logic wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign restart = wr_en;
  assign prdata  = paddr[2] ? APB_DATA_W'(image_cols) : APB_DATA_W'(image_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ROWS_RESET;
      image_cols <= COLS_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ADDR_IMAGE_ROWS[2]: image_rows <= clamp_size(pwdata[CFG_W-1:0], MAX_ROWS);
        ADDR_IMAGE_COLS[2]: image_cols <= clamp_size(pwdata[CFG_W-1:0], MAX_COLS);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cnmd_line_mem.sv =====
// Two-line store: one synchronous memory word per column holds the upper and
// middle rows. Depends on cnmd_pkg.
`default_nettype none
module cnmd_line_mem #(
  parameter int DEPTH = 512
) (
  input  wire logic                             clk,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output cnmd_pkg::line_word_t                  rd_data,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire cnmd_pkg::line_word_t             wr_data
);
  import cnmd_pkg::*;

  line_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/cnmd_classify.sv =====
// 3x3 window, crossing-number test and the result register of the detector.
// Depends on cnmd_pkg.
`default_nettype none
module cnmd_classify (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire cnmd_pkg::stage_ctrl_t                ctrl,
  input  wire cnmd_pkg::line_entry_t                item,
  input  wire cnmd_pkg::line_word_t                 lines,
  input  wire logic [cnmd_pkg::POS_OUT_W-1:0]       center_row,
  input  wire logic [cnmd_pkg::POS_OUT_W-1:0]       center_col,
  output logic                                      m_tvalid,
  output logic      [cnmd_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                      m_tuser
);
  import cnmd_pkg::*;

  logic [8:0]          window;
  logic [8:0]          window_next;
  logic [ORIENT_W-1:0] center_orientation;
  ring_class_t         ring;

  assign window_next = {window[5:0], item.ridge, lines.middle.ridge, lines.upper.ridge};
  assign ring        = classify_ring(window_next);

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      window             <= '0;
      center_orientation <= '0;
      m_tvalid           <= 1'b0;
    end else if (ctrl.advance) begin
      m_tvalid <= 1'b0;
      if (ctrl.item_valid) begin
        window             <= window_next;
        center_orientation <= lines.middle.orient;
        m_tvalid           <= ctrl.interior && window_next[4] && ring.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance && ctrl.item_valid) begin
      m_tdata <= {6'd0, center_orientation, center_col, center_row};
      m_tuser <= ring.kind;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/crossing_number_minutiae_detect.sv =====
// Top level of the crossing-number minutiae detector: raster position, line
// store pipeline and configuration. Depends on cnmd_pkg and all cnmd_ modules.
//
// The block takes one thinned pixel per clock cycle unless the output stalls; a
// result passes the s1 and result registers after the minutia's lower-right pixel
// is accepted. The line memory, read and written once per pixel, sets the rate.
// Column accesses are at least three pixels apart, so no forwarding is needed.
// Results appear only for interior pixels; configuration writes restart the frame.
`default_nettype none
module crossing_number_minutiae_detect #(
  parameter int MAX_COLS = 512,
  parameter int MAX_ROWS = 512
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // Fields from bit 0: ridge_pixel[0], orientation[8:1], zero fill.
  input  wire logic [cnmd_pkg::S_TDATA_W-1:0]     s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // Fields from bit 0: minutia_row[8:0], minutia_col[17:9],
  // minutia_orientation[25:18], zero fill.
  output logic      [cnmd_pkg::M_TDATA_W-1:0]     m_tdata,
  // Fields from bit 0: minutia_kind[0].
  output logic                                    m_tuser,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [cnmd_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [cnmd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [cnmd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready
);
  import cnmd_pkg::*;

  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CMPW = ((CW > RW ? CW : RW) > CFG_W ? (CW > RW ? CW : RW) : CFG_W) + 1;

  logic [CFG_W-1:0] image_rows;
  logic [CFG_W-1:0] image_cols;
  logic             restart;

  logic [CW-1:0]    col_pos;
  logic [RW-1:0]    row_pos;
  logic [CMPW-1:0]  col_inc;
  logic [CMPW-1:0]  row_inc;

  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  logic [RW-1:0]    s1_row;
  line_entry_t      s1_item;

  logic             advance;
  logic             accept;
  line_word_t       rd_data;
  line_word_t       wr_data;
  stage_ctrl_t      ctrl;
  logic [31:0]      row_m1;
  logic [31:0]      col_m1;

  cnmd_cfg #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .image_rows(image_rows),
    .image_cols(image_cols),
    .restart   (restart)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;
  assign accept   = s_tvalid && s_tready;

  assign col_inc = CMPW'(col_pos) + CMPW'(1);
  assign row_inc = CMPW'(row_pos) + CMPW'(1);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_pos  <= '0;
      row_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (col_inc >= CMPW'(image_cols)) begin
          col_pos <= '0;
          row_pos <= (row_inc >= CMPW'(image_rows)) ? '0 : row_inc[RW-1:0];
        end else begin
          col_pos <= col_inc[CW-1:0];
        end
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col         <= col_pos;
      s1_row         <= row_pos;
      s1_item.ridge  <= s_tdata[0];
      s1_item.orient <= s_tdata[ORIENT_W:1];
    end
  end

  assign wr_data.middle = s1_item;
  assign wr_data.upper  = rd_data.middle;

  cnmd_line_mem #(
    .DEPTH(MAX_COLS)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(col_pos),
    .rd_data(rd_data),
    .wr_en  (advance && s1_valid),
    .wr_addr(s1_col),
    .wr_data(wr_data)
  );

  assign row_m1 = 32'(s1_row) - 32'd1;
  assign col_m1 = 32'(s1_col) - 32'd1;

  assign ctrl.advance    = advance;
  assign ctrl.item_valid = s1_valid;
  assign ctrl.interior   = (32'(s1_row) >= 32'd2) && (32'(s1_col) >= 32'd2);
  assign ctrl.restart    = restart;

  cnmd_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .item      (s1_item),
    .lines     (rd_data),
    .center_row(row_m1[POS_OUT_W-1:0]),
    .center_col(col_m1[POS_OUT_W-1:0]),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
`default_nettype wire
